// ===== rtl/ddpu_pkg.sv =====
`timescale 1ns / 1ps
package ddpu_pkg;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_rate;
    logic        [15:0] time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [15:0] new_heading;
  } out_word_t;

  // heading in Q2.13
  localparam int HEAD_PI     = 25736;
  localparam int HEAD_TWO_PI = 51472;

  // CORDIC: angle in Q.16, vector in Q1.30
  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 33;
  localparam int AW           = 20;
  localparam int ANG_HALF_PI  = 102944;
  localparam int ANG_PI       = 205888;
  localparam int CORDIC_GAIN  = 652032874;

  localparam logic signed [AW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047, 20'sd1024,
    20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16, 20'sd8, 20'sd4, 20'sd2
  };

  // arc divider: numerator < 2^50, divisor = |w|*1024 >= 1024, so the top
  // NW-QW quotient bits are always zero
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 26;
  localparam int DIV_QW = 40;

  localparam logic [7:0] THRESH_RESET = 8'd1;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/diff_drive_pose_update.sv =====
`timescale 1ns / 1ps
// Differential-drive arc odometry, one pose step per word.
// Input channel in_valid / in_stall / in_data carries the current pose and
// the command; output channel out_valid / out_stall / out_data returns the
// next pose. A word moves when valid is high and stall is low.
// cfg_we / cfg_data write straight_threshold (reset value 1); write it only
// while the pipeline is empty.
// From input accept to out_valid a word passes 2 input stages,
// 17 CORDIC stages (old and new heading side by side), 2 multiply/scale
// stages, 41 stages of the bit-per-stage arc divider and the output register.
// Throughput is one word per cycle while the output is not stalled; the straight-line path rides through the
// same stages so order is kept.
// The whole pipeline advances as one: while out_valid is high and out_stall
// is high every stage holds and in_stall is raised, so nothing is lost or
// repeated. Synchronous reset clears all valid bits and sets the threshold
// back to 1.
module diff_drive_pose_update (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ddpu_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ddpu_pkg::out_word_t   out_data,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data
);

  localparam int CW  = ddpu_pkg::CW;
  localparam int CL  = ddpu_pkg::CORDIC_STEPS + 1;
  localparam int DL  = ddpu_pkg::DIV_QW + 1;
  localparam int NW  = ddpu_pkg::DIV_NW;
  localparam int DW  = ddpu_pkg::DIV_DW;
  localparam int QW  = ddpu_pkg::DIV_QW;

  localparam logic signed [18:0] W_PI    = 19'(ddpu_pkg::HEAD_PI);
  localparam logic signed [18:0] W_2PI   = 19'(ddpu_pkg::HEAD_TWO_PI);
  localparam logic signed [18:0] W_3PI   = 19'(ddpu_pkg::HEAD_PI + ddpu_pkg::HEAD_TWO_PI);
  localparam logic signed [18:0] W_4PI   = 19'(2 * ddpu_pkg::HEAD_TWO_PI);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] hd;
    logic signed [15:0] t;
    logic signed [15:0] v;
    logic               wneg;
    logic [15:0]        aw;
    logic               str;
    logic signed [32:0] vdt;
  } cband_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] nh;
    logic               str;
    logic signed [27:0] sx;
    logic signed [27:0] sy;
    logic               sgnx;
    logic               sgny;
  } dband_t;

  logic       adv;
  logic [7:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ddpu_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: products with dt
  logic signed [32:0] wdt1, vdt1;
  logic [15:0]        aw1;
  logic               str1;

  assign wdt1 = 33'(in_data.angular_rate) * 33'($signed({1'b0, in_data.time_step}));
  assign vdt1 = 33'(in_data.linear_speed) * 33'($signed({1'b0, in_data.time_step}));
  assign aw1  = in_data.angular_rate[15] ? 16'(-in_data.angular_rate)
                                         : in_data.angular_rate;
  // w == 0 always goes straight, even with a zero threshold
  assign str1 = (in_data.angular_rate == 16'sd0) || (aw1 < {8'b0, thr_r});

  logic               vld1_r;
  logic signed [31:0] px1_r, py1_r;
  logic signed [15:0] hd1_r, v1_r;
  logic               wneg1_r, str1_r;
  logic [15:0]        aw1_r;
  logic signed [32:0] wdt1_r, vdt1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r   <= in_data.pose_x;
      py1_r   <= in_data.pose_y;
      hd1_r   <= in_data.pose_heading;
      v1_r    <= in_data.linear_speed;
      wneg1_r <= in_data.angular_rate[15];
      aw1_r   <= aw1;
      str1_r  <= str1;
      wdt1_r  <= wdt1;
      vdt1_r  <= vdt1;
    end
  end

  // ---------------- stage 2: new heading and wrap
  logic signed [32:0] dsum2;
  logic signed [17:0] d2;
  logic signed [18:0] traw2, tw2;

  always_comb begin
    dsum2 = (wdt1_r + 33'sd16384) >>> 15;
    d2    = dsum2[17:0];
    traw2 = {{3{hd1_r[15]}}, hd1_r} + {d2[17], d2};
    if (traw2 > W_3PI) begin
      tw2 = traw2 - W_4PI;
    end else if (traw2 > W_PI) begin
      tw2 = traw2 - W_2PI;
    end else if (traw2 < -W_3PI) begin
      tw2 = traw2 + W_4PI;
    end else if (traw2 < -W_PI) begin
      tw2 = traw2 + W_2PI;
    end else begin
      tw2 = traw2;
    end
  end

  logic   vld2_r;
  cband_t c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r.px   <= px1_r;
      c2_r.py   <= py1_r;
      c2_r.hd   <= hd1_r;
      c2_r.t    <= tw2[15:0];
      c2_r.v    <= v1_r;
      c2_r.wneg <= wneg1_r;
      c2_r.aw   <= aw1_r;
      c2_r.str  <= str1_r;
      c2_r.vdt  <= vdt1_r;
    end
  end

  // ---------------- CORDIC, old and new heading
  logic signed [CW-1:0] s0, c0, s1, c1;

  ddpu_cordic u_cordic_old (
    .clk   (clk),
    .en    (adv),
    .head  (c2_r.hd),
    .sin_o (s0),
    .cos_o (c0)
  );

  ddpu_cordic u_cordic_new (
    .clk   (clk),
    .en    (adv),
    .head  (c2_r.t),
    .sin_o (s1),
    .cos_o (c1)
  );

  cband_t cs_r   [CL];
  logic   vldc_r [CL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CL; k++) begin
        vldc_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vldc_r[0] <= vld2_r;
      for (int k = 1; k < CL; k++) begin
        vldc_r[k] <= vldc_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r[0] <= c2_r;
      for (int k = 1; k < CL; k++) begin
        cs_r[k] <= cs_r[k-1];
      end
    end
  end

  // ---------------- stage 3: products
  cband_t             cq;
  logic signed [CW:0] dsx3, dcy3;

  assign cq   = cs_r[CL-1];
  assign dsx3 = {s1[CW-1], s1} - {s0[CW-1], s0};
  assign dcy3 = {c0[CW-1], c0} - {c1[CW-1], c1};

  logic               vld3_r;
  logic signed [31:0] px3_r, py3_r;
  logic signed [15:0] nh3_r;
  logic               str3_r, wneg3_r;
  logic [15:0]        aw3_r;
  logic signed [65:0] prodx3_r, prody3_r;
  logic signed [NW-1:0] numx3_r, numy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld3_r <= vldc_r[CL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px3_r    <= cq.px;
      py3_r    <= cq.py;
      nh3_r    <= cq.str ? cq.hd : cq.t;
      str3_r   <= cq.str;
      wneg3_r  <= cq.wneg;
      aw3_r    <= cq.aw;
      prodx3_r <= 66'(cq.vdt) * 66'(c0);
      prody3_r <= 66'(cq.vdt) * 66'(s0);
      numx3_r  <= NW'(cq.v) * NW'(dsx3);
      numy3_r  <= NW'(cq.v) * NW'(dcy3);
    end
  end

  // ---------------- stage 4: straight rounding, divider operands
  logic signed [65:0] shx4, shy4;
  logic [NW-1:0]      anx4, any4;

  assign shx4 = (prodx3_r + (66'sd1 <<< 37)) >>> 38;
  assign shy4 = (prody3_r + (66'sd1 <<< 37)) >>> 38;
  assign anx4 = numx3_r[NW-1] ? NW'(-numx3_r) : NW'(numx3_r);
  assign any4 = numy3_r[NW-1] ? NW'(-numy3_r) : NW'(numy3_r);

  logic          vld4_r;
  dband_t        d4_r;
  logic [NW-1:0] nx4_r, ny4_r;
  logic [DW-1:0] den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_r.px   <= px3_r;
      d4_r.py   <= py3_r;
      d4_r.nh   <= nh3_r;
      d4_r.str  <= str3_r;
      d4_r.sx   <= shx4[27:0];
      d4_r.sy   <= shy4[27:0];
      d4_r.sgnx <= numx3_r[NW-1] ^ wneg3_r;
      d4_r.sgny <= numy3_r[NW-1] ^ wneg3_r;
      // add half the divisor for round half away
      nx4_r     <= anx4 + NW'({aw3_r, 9'b0});
      ny4_r     <= any4 + NW'({aw3_r, 9'b0});
      den4_r    <= {aw3_r, 10'b0};
    end
  end

  // ---------------- arc division
  logic [QW-1:0] qx, qy;

  ddpu_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (nx4_r),
    .den (den4_r),
    .quo (qx)
  );

  ddpu_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (ny4_r),
    .den (den4_r),
    .quo (qy)
  );

  dband_t ds_r   [DL];
  logic   vldd_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DL; k++) begin
        vldd_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vldd_r[0] <= vld4_r;
      for (int k = 1; k < DL; k++) begin
        vldd_r[k] <= vldd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r[0] <= d4_r;
      for (int k = 1; k < DL; k++) begin
        ds_r[k] <= ds_r[k-1];
      end
    end
  end

  // ---------------- output: select, add, saturate
  dband_t             dq;
  logic signed [QW:0] sqx, sqy, dlx, dly;
  logic signed [41:0] sumx, sumy;
  ddpu_pkg::out_word_t out_nxt;

  always_comb begin
    dq   = ds_r[DL-1];
    sqx  = dq.sgnx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    sqy  = dq.sgny ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    dlx  = dq.str ? (QW+1)'(dq.sx) : sqx;
    dly  = dq.str ? (QW+1)'(dq.sy) : sqy;
    sumx = 42'(dq.px) + 42'(dlx);
    sumy = 42'(dq.py) + 42'(dly);
    out_nxt.new_x       = ddpu_pkg::sat32(sumx);
    out_nxt.new_y       = ddpu_pkg::sat32(sumy);
    out_nxt.new_heading = dq.nh;
  end

  logic                out_valid_r;
  ddpu_pkg::out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vldd_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vldd_r[DL-1] |=> out_valid)
    else $error("word at divider exit not presented");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (vld4_r == $past(vld4_r)) && (vldc_r[0] == $past(vldc_r[0])))
    else $error("pipeline moved while output stalled");

endmodule

// ===== rtl/ddpu_cordic.sv =====
`timescale 1ns / 1ps
module ddpu_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [15:0]               head,
  output logic signed [ddpu_pkg::CW-1:0]   sin_o,
  output logic signed [ddpu_pkg::CW-1:0]   cos_o
);

  localparam int N  = ddpu_pkg::CORDIC_STEPS;
  localparam int CW = ddpu_pkg::CW;
  localparam int AW = ddpu_pkg::AW;
  localparam logic signed [AW-1:0] HALF_PI_A = AW'(ddpu_pkg::ANG_HALF_PI);
  localparam logic signed [AW-1:0] PI_A      = AW'(ddpu_pkg::ANG_PI);
  localparam logic signed [CW-1:0] GAIN      = CW'(ddpu_pkg::CORDIC_GAIN);

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic signed [AW-1:0] a_r [N+1];
  logic                 neg_r [N+1];

  logic signed [AW-1:0] a_in;
  logic signed [AW-1:0] a_fold;
  logic                 neg_in;

  always_comb begin
    a_in   = {head[15], head, 3'b000};
    a_fold = a_in;
    neg_in = 1'b0;
    // fold into [-pi/2, pi/2], negate both outputs
    if (a_in > HALF_PI_A) begin
      a_fold = a_in - PI_A;
      neg_in = 1'b1;
    end else if (a_in < -HALF_PI_A) begin
      a_fold = a_in + PI_A;
      neg_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= GAIN;
      y_r[0]   <= '0;
      a_r[0]   <= a_fold;
      neg_r[0] <= neg_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (a_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] - ddpu_pkg::ATAN_Q16[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          a_r[i+1] <= a_r[i] + ddpu_pkg::ATAN_Q16[i];
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign sin_o = neg_r[N] ? -y_r[N] : y_r[N];
  assign cos_o = neg_r[N] ? -x_r[N] : x_r[N];

endmodule

// ===== rtl/ddpu_div.sv =====
`timescale 1ns / 1ps
module ddpu_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ddpu_pkg::DIV_NW-1:0]   num,
  input  logic [ddpu_pkg::DIV_DW-1:0]   den,
  output logic [ddpu_pkg::DIV_QW-1:0]   quo
);

  localparam int NW = ddpu_pkg::DIV_NW;
  localparam int DW = ddpu_pkg::DIV_DW;
  localparam int QW = ddpu_pkg::DIV_QW;

  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] d_r   [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num[NW-1:QW]);
      lo_r[0]  <= num[QW-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= den;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    assign trial = {rem_r[k], lo_r[k][QW-1]};
    assign diff  = trial - {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, d_r[k]}) begin
          rem_r[k+1] <= diff[DW-1:0];
          q_r[k+1]   <= {q_r[k][QW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= trial[DW-1:0];
          q_r[k+1]   <= {q_r[k][QW-2:0], 1'b0};
        end
        lo_r[k+1] <= lo_r[k] << 1;
        d_r[k+1]  <= d_r[k];
      end
    end
  end

  assign quo = q_r[QW];

endmodule

// ===== tb/pose_update_checker.sv =====
`timescale 1ns / 1ps
module pose_update_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ddpu_pkg::in_word_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ddpu_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   arc_count,
  output int                   straight_count,
  output int                   sat_count
);

  localparam longint ATAN_TAB [ddpu_pkg::CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };

  logic [7:0]          thresh;
  ddpu_pkg::out_word_t pose_q[$];

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  task automatic cordic_sincos(input longint head, output longint s, output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    a = head * 8;
    flip = 0;
    x = ddpu_pkg::CORDIC_GAIN;
    y = 0;
    if (a > ddpu_pkg::ANG_HALF_PI) begin
      a -= ddpu_pkg::ANG_PI;
      flip = 1;
    end else if (a < -ddpu_pkg::ANG_HALF_PI) begin
      a += ddpu_pkg::ANG_PI;
      flip = 1;
    end
    for (int i = 0; i < ddpu_pkg::CORDIC_STEPS; i++) begin
      dx = fl_shift(y, i);
      dy = fl_shift(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; a += ATAN_TAB[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint rnd_div(longint n, longint d);
    longint an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (an + ad / 2) / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_pose(input ddpu_pkg::in_word_t w_in,
                              output ddpu_pkg::out_word_t r);
    longint px, py, hd, v, w, dt, aw, nx, ny, nh, s0, c0, s1, c1, t;
    px = w_in.pose_x;
    py = w_in.pose_y;
    hd = w_in.pose_heading;
    v  = w_in.linear_speed;
    w  = w_in.angular_rate;
    dt = longint'(w_in.time_step);
    aw = w < 0 ? -w : w;
    cordic_sincos(hd, s0, c0);
    if (w == 0 || aw < longint'(thresh)) begin
      nx = px + fl_shift(v * c0 * dt + (64'sd1 <<< 37), 38);
      ny = py + fl_shift(v * s0 * dt + (64'sd1 <<< 37), 38);
      nh = hd;
      straight_count++;
    end else begin
      t = hd + fl_shift(w * dt + (64'sd1 <<< 14), 15);
      while (t > ddpu_pkg::HEAD_PI) t -= ddpu_pkg::HEAD_TWO_PI;
      while (t < -ddpu_pkg::HEAD_PI) t += ddpu_pkg::HEAD_TWO_PI;
      cordic_sincos(t, s1, c1);
      nx = px + rnd_div(v * (s1 - s0), w * 1024);
      ny = py + rnd_div(v * (c0 - c1), w * 1024);
      nh = t;
      arc_count++;
    end
    if (clamp32(nx) != nx || clamp32(ny) != ny) sat_count++;
    r.new_x = 32'(clamp32(nx));
    r.new_y = 32'(clamp32(ny));
    r.new_heading = nh[15:0];
  endtask

  always @(posedge clk) begin
    ddpu_pkg::out_word_t exp_w;
    int errs;
    errs = 0;
    if (!rst_n) begin
      thresh <= ddpu_pkg::THRESH_RESET;
      pose_q.delete();
      fail_count <= 0;
      arc_count = 0;
      straight_count = 0;
      sat_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pose(in_data, exp_w);
        pose_q.push_back(exp_w);
      end
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $error("unexpected word: %p", out_data);
          errs++;
        end else begin
          exp_w = pose_q.pop_front();
          if (out_data.new_x !== exp_w.new_x) begin
            $error("new_x expected %0d actual %0d", exp_w.new_x, out_data.new_x);
            errs++;
          end
          if (out_data.new_y !== exp_w.new_y) begin
            $error("new_y expected %0d actual %0d", exp_w.new_y, out_data.new_y);
            errs++;
          end
          if (out_data.new_heading !== exp_w.new_heading) begin
            $error("new_heading expected %0d actual %0d", exp_w.new_heading,
                   out_data.new_heading);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (cfg_we) thresh <= cfg_data;
    end
    pending = pose_q.size();
  end

endmodule

// ===== tb/tb_diff_drive_pose_update.sv =====
`timescale 1ns / 1ps
module tb_diff_drive_pose_update;

  localparam int LATENCY   = 63;
  localparam int MAX_CYCLE = 400000;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_stall;
  ddpu_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 0;
  ddpu_pkg::out_word_t out_data;
  logic                cfg_we = 0;
  logic [7:0]          cfg_data = '0;
  int                  fail_count, pending, arc_count, straight_count, sat_count;
  int                  cycle = 0;
  bit                  calm = 0;
  bit                  hold_out = 0;

  always #10 clk = ~clk;

  diff_drive_pose_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  pose_update_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .arc_count(arc_count),
    .straight_count(straight_count), .sat_count(sat_count)
  );

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("timeout at cycle %0d", cycle);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall, at random unless in a calm stretch or a long hold-off
  always @(negedge clk) begin
    out_stall <= hold_out || (!calm && $urandom_range(99) < 12);
  end

  task automatic send_word(input ddpu_pkg::in_word_t w);
    in_data <= w;
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 0;
      do @(negedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_thresh(input logic [7:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic signed [15:0] rand_heading();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return ($urandom_range(1)) ? 16'sd25736 : -16'sd25736;
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  function automatic ddpu_pkg::in_word_t rand_word();
    ddpu_pkg::in_word_t w;
    int r;
    w.pose_x = $urandom;
    w.pose_y = $urandom;
    if ($urandom_range(3) == 0) begin
      w.pose_x = $signed($urandom_range(2000)) - 1000;
      w.pose_y = $signed($urandom_range(2000)) - 1000;
    end
    w.pose_heading = rand_heading();
    w.linear_speed = 16'($urandom);
    r = $urandom_range(9);
    if (r < 3) w.angular_rate = 16'($signed($urandom_range(600)) - 300);
    else if (r == 3) w.angular_rate = 0;
    else w.angular_rate = 16'($urandom);
    w.time_step = 16'($urandom);
    return w;
  endfunction

  function automatic ddpu_pkg::in_word_t mk(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [15:0] h, logic signed [15:0] v,
                                            logic signed [15:0] a, logic [15:0] t);
    ddpu_pkg::in_word_t w;
    w.pose_x = x; w.pose_y = y; w.pose_heading = h;
    w.linear_speed = v; w.angular_rate = a; w.time_step = t;
    return w;
  endfunction

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, zero turn, near-threshold, out-of-range heading, large arcs
    calm = 1;
    send_word(mk(0, 0, 0, 256, 0, 16'hffff));
    send_word(mk(32'sh7fffffff, 32'sh7fffffff, 16'sd25736, 16'sh7fff, 0, 16'hffff));
    send_word(mk(32'sh80000000, 32'sh80000000, -16'sd25736, -16'sd32768, 0, 16'hffff));
    send_word(mk(0, 0, 16'sh7fff, 16'sh7fff, 16'sd1, 16'hffff));
    send_word(mk(0, 0, -16'sd32768, -16'sd32768, -16'sd1, 16'hffff));
    send_word(mk(100, -100, 16'sd12868, 16'sh7fff, 16'sh7fff, 16'hffff));
    send_word(mk(-5, 5, -16'sd12868, 16'sh7fff, -16'sd32768, 16'hffff));
    send_word(mk(32'sh7fff0000, 0, 0, 16'sh7fff, 16'sd1, 16'hffff));
    send_word(mk(0, 32'sh80010000, 16'sd20000, -16'sd32768, -16'sd1, 16'hffff));
    send_word(mk(0, 0, 16'sd25000, 16'sd512, 16'sd4096, 16'hffff));
    send_word(mk(0, 0, -16'sd25000, 16'sd512, -16'sd4096, 16'hffff));
    send_word(mk(0, 0, 16'sd100, 16'sd256, 16'sd2000, 16'd0));
    send_word(mk(1, 1, 16'sd30000, 16'sd256, 16'sd0, 16'd1000));
    send_word(mk(1, 1, -16'sd30000, 16'sd256, 16'sd3000, 16'd1000));
    go_idle();

    for (int i = 0; i < 4; i++) begin
      case (i)
        0: write_thresh(8'd0);
        1: write_thresh(8'd255);
        2: write_thresh(8'd40);
        default: write_thresh(8'd1);
      endcase
      send_word(mk(0, 0, 16'sd1000, 16'sd256, 16'sd0, 16'hffff));
      send_word(mk(0, 0, 16'sd1000, 16'sd256, 16'sd254, 16'hffff));
      send_word(mk(0, 0, 16'sd1000, 16'sd256, -16'sd255, 16'hffff));
      send_word(mk(0, 0, 16'sd1000, 16'sd256, 16'sd39, 16'hffff));
      send_word(mk(0, 0, 16'sd1000, 16'sd256, 16'sd40, 16'hffff));
      go_idle();
    end

    // random phases under several thresholds
    for (int ph = 0; ph < 4; ph++) begin
      write_thresh(ph == 0 ? 8'd1 : ph == 1 ? 8'd255 : ph == 2 ? 8'd0 : 8'($urandom));
      calm = (ph == 1);
      if (ph == 2) begin
        // long receiver hold-off while words keep coming
        fork
          begin
            hold_out = 1;
            repeat (200) @(negedge clk);
            hold_out = 0;
          end
          for (int k = 0; k < 100; k++) send_word(rand_word());
        join
      end
      for (int k = 0; k < 370; k++) send_word(rand_word());
      go_idle();
    end

    $display("covered %0d arc and %0d straight updates, %0d saturated, thresholds 0..255",
             arc_count, straight_count, sat_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
